/* sv/css_pkg.sv */
package css_pkg;

	// Field widths.
	localparam int TICK_BITS  = 16;
	localparam int COUNT_BITS = 9;

	// Configuration port geometry.
	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_FULL_LINE  = 3'd0;
	localparam logic [2:0] REG_HALF_LINE  = 3'd1;
	localparam logic [2:0] REG_LONG_SYNC  = 3'd2;
	localparam logic [2:0] REG_SHORT_SYNC = 3'd3;
	localparam logic [2:0] REG_LINES      = 3'd4;
	localparam logic [2:0] REG_FIELD_SEL  = 3'd5;

	// Register reset values: 64 us, 32 us, 4.7 us and 2.35 us at 84 ticks per microsecond.
	localparam logic [TICK_BITS-1:0]  FULL_LINE_RST  = TICK_BITS'(5376);
	localparam logic [TICK_BITS-1:0]  HALF_LINE_RST  = TICK_BITS'(2688);
	localparam logic [TICK_BITS-1:0]  LONG_SYNC_RST  = TICK_BITS'(395);
	localparam logic [TICK_BITS-1:0]  SHORT_SYNC_RST = TICK_BITS'(197);
	localparam logic [COUNT_BITS-1:0] LINES_RST      = COUNT_BITS'(304);
	localparam logic                  FIELD_SEL_RST  = 1'b1;

	// Last count of each vertical interval phase, and the post phase count that swaps the period.
	localparam logic [COUNT_BITS-1:0] PRE_LAST   = COUNT_BITS'(5);
	localparam logic [COUNT_BITS-1:0] VSYNC_LAST = COUNT_BITS'(4);
	localparam logic [COUNT_BITS-1:0] POST_SWAP  = COUNT_BITS'(3);
	localparam logic [COUNT_BITS-1:0] POST_LAST  = COUNT_BITS'(4);

	typedef enum logic [1:0] {
		PH_PRE   = 2'd0,
		PH_VSYNC = 2'd1,
		PH_POST  = 2'd2,
		PH_VIDEO = 2'd3
	} phase_t;

	typedef struct packed {
		logic [TICK_BITS-1:0]  full_line_ticks;
		logic [TICK_BITS-1:0]  half_line_ticks;
		logic [TICK_BITS-1:0]  long_sync_ticks;
		logic [TICK_BITS-1:0]  short_sync_ticks;
		logic [COUNT_BITS-1:0] lines_per_field;
		logic                  first_field_sel;
	} cfg_t;

endpackage

/* sv/css_regs.sv */
module css_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [css_pkg::ADDR_BITS-1:0] paddr,
	input  logic [css_pkg::DATA_BITS-1:0] pwdata,
	output logic [css_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	output css_pkg::cfg_t                 cfg
);

	css_pkg::cfg_t cfg_q;
	logic [2:0]    reg_idx;
	logic          wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	// Register writes on the access cycle of a write request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_line_ticks  <= css_pkg::FULL_LINE_RST;
			cfg_q.half_line_ticks  <= css_pkg::HALF_LINE_RST;
			cfg_q.long_sync_ticks  <= css_pkg::LONG_SYNC_RST;
			cfg_q.short_sync_ticks <= css_pkg::SHORT_SYNC_RST;
			cfg_q.lines_per_field  <= css_pkg::LINES_RST;
			cfg_q.first_field_sel  <= css_pkg::FIELD_SEL_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				css_pkg::REG_FULL_LINE:  cfg_q.full_line_ticks  <= pwdata[css_pkg::TICK_BITS-1:0];
				css_pkg::REG_HALF_LINE:  cfg_q.half_line_ticks  <= pwdata[css_pkg::TICK_BITS-1:0];
				css_pkg::REG_LONG_SYNC:  cfg_q.long_sync_ticks  <= pwdata[css_pkg::TICK_BITS-1:0];
				css_pkg::REG_SHORT_SYNC: cfg_q.short_sync_ticks <= pwdata[css_pkg::TICK_BITS-1:0];
				css_pkg::REG_LINES:      cfg_q.lines_per_field  <= pwdata[css_pkg::COUNT_BITS-1:0];
				css_pkg::REG_FIELD_SEL:  cfg_q.first_field_sel  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		unique case (reg_idx)
			css_pkg::REG_FULL_LINE:  prdata = css_pkg::DATA_BITS'(cfg_q.full_line_ticks);
			css_pkg::REG_HALF_LINE:  prdata = css_pkg::DATA_BITS'(cfg_q.half_line_ticks);
			css_pkg::REG_LONG_SYNC:  prdata = css_pkg::DATA_BITS'(cfg_q.long_sync_ticks);
			css_pkg::REG_SHORT_SYNC: prdata = css_pkg::DATA_BITS'(cfg_q.short_sync_ticks);
			css_pkg::REG_LINES:      prdata = css_pkg::DATA_BITS'(cfg_q.lines_per_field);
			css_pkg::REG_FIELD_SEL:  prdata = css_pkg::DATA_BITS'(cfg_q.first_field_sel);
			default:                 prdata = '0;
		endcase
	end

endmodule

/* sv/composite_sync_sequencer_top.sv */
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; the sequencer state
// register updates in a single pass; the result is read straight from it until taken.
// Reset: arst_n clears the result valid flag, puts the sequencer in the video lines phase
// with the counter at 303, full line period and long sync pulse, and loads register defaults.
module composite_sync_sequencer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [0] tick
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [15:0] period_ticks, [31:16] pulse_ticks, [33:32] phase, [42:34] line_count
	output logic [47:0]                   m_axis_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [css_pkg::ADDR_BITS-1:0] paddr,
	input  logic [css_pkg::DATA_BITS-1:0] pwdata,
	output logic [css_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready
);

	localparam int TB = css_pkg::TICK_BITS;
	localparam int CB = css_pkg::COUNT_BITS;

	css_pkg::cfg_t   cfg;
	css_pkg::phase_t phase_q, phase_d;
	logic [CB-1:0]   count_q, count_d;
	logic [TB-1:0]   period_q, period_d;
	logic [TB-1:0]   pulse_q, pulse_d;
	logic [TB-1:0]   vsync_pulse;
	logic [CB-1:0]   count_inc;
	logic            out_valid_q;
	logic            accept;
	logic            tick;

	css_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// A new request is taken when the result slot is empty or drains this cycle.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign tick          = s_axis_tdata[0];

	// Vertical sync pulse is half line minus long sync, floored at zero.
	assign vsync_pulse = (cfg.half_line_ticks >= cfg.long_sync_ticks)
		? (cfg.half_line_ticks - cfg.long_sync_ticks) : '0;
	assign count_inc = count_q + CB'(1);

	// Next sequencer state for one line timer overflow.
	always_comb begin
		phase_d  = phase_q;
		count_d  = count_inc;
		period_d = period_q;
		pulse_d  = pulse_q;
		unique case (phase_q)
			css_pkg::PH_VIDEO: begin
				if (count_q == cfg.lines_per_field) begin
					if (!cfg.first_field_sel) period_d = cfg.half_line_ticks;
					phase_d = css_pkg::PH_PRE;
					count_d = '0;
				end
			end
			css_pkg::PH_PRE: begin
				if (count_q == '0) begin
					pulse_d = cfg.short_sync_ticks;
					if (cfg.first_field_sel) period_d = cfg.half_line_ticks;
				end else if (count_q == css_pkg::PRE_LAST) begin
					phase_d = css_pkg::PH_VSYNC;
					pulse_d = vsync_pulse;
					count_d = '0;
				end
			end
			css_pkg::PH_VSYNC: begin
				if (count_q == css_pkg::VSYNC_LAST) begin
					phase_d = css_pkg::PH_POST;
					pulse_d = cfg.short_sync_ticks;
					count_d = '0;
				end
			end
			css_pkg::PH_POST: begin
				if (count_q == css_pkg::POST_SWAP) begin
					if (!cfg.first_field_sel) period_d = cfg.full_line_ticks;
				end else if (count_q == css_pkg::POST_LAST) begin
					if (cfg.first_field_sel) period_d = cfg.full_line_ticks;
					pulse_d = cfg.long_sync_ticks;
					phase_d = css_pkg::PH_VIDEO;
					count_d = '0;
				end
			end
			default: ;
		endcase
	end

	// Sequencer state; it doubles as the result register since it only moves on a request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= css_pkg::PH_VIDEO;
			count_q     <= css_pkg::LINES_RST - CB'(1);
			period_q    <= css_pkg::FULL_LINE_RST;
			pulse_q     <= css_pkg::LONG_SYNC_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				if (tick) begin
					phase_q  <= phase_d;
					count_q  <= count_d;
					period_q <= period_d;
					pulse_q  <= pulse_d;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, count_q, phase_q, pulse_q, period_q};

endmodule
